// File: rtl/clint_pkg.sv
// Shared constants, types and address map of the core-local interruptor.
`default_nettype none

package clint_pkg;

   // Hart count and derived widths
   localparam int HARTS  = 4;
   localparam int HART_W = (HARTS > 1) ? $clog2(HARTS) : 1;
   localparam int IRQ_W  = 4;
   localparam int ADDR_W = 16;
   localparam int DATA_W = 32;
   localparam int TIME_W = 64;

   // Address map (byte offsets)
   localparam logic [ADDR_W-1:0] MSIP_BASE   = 16'h0000;
   localparam logic [ADDR_W-1:0] CMP_BASE    = 16'h4000;
   localparam logic [ADDR_W-1:0] TIME_BASE   = 16'hBFF8;
   localparam int                MSIP_STRIDE = 4;
   localparam int                CMP_STRIDE  = 8;
   localparam logic [ADDR_W-1:0] MSIP_END    = ADDR_W'(MSIP_STRIDE * HARTS);
   localparam logic [ADDR_W-1:0] CMP_END     = ADDR_W'(16'h4000 + CMP_STRIDE * HARTS);

   // Command codes
   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // Address decode result
   typedef struct packed {
      logic              msip_hit;
      logic              cmp_hit;
      logic              time_hit;
      logic              hi;
      logic [HART_W-1:0] hart;
      logic              err;
   } dec_type;

endpackage

`default_nettype wire

// File: rtl/core_local_timer_interruptor.sv
// Top level of the core-local interruptor: request register, state update, result register.
// Takes one word read, word write or timer tick per clock, unless a request is held by a
// waiting result. A request is held in the request register, where it is decoded and applied
// to the time counter, compare values and software-pending bits; the result register is loaded
// as the request leaves the request register, with the read word, the error flag and the
// interrupt lines as they stand after that request. The cycle budget is set by the 64-bit
// increment of the time counter feeding the per-hart 64-bit compares. A new request is taken
// while a result waits, as long as the request register is empty. Reset leaves time at zero,
// every compare value at all ones and no software interrupt pending.
`default_nettype none

module core_local_timer_interruptor
   import clint_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_cmd,
   input  wire logic [ADDR_W-1:0] req_addr,
   input  wire logic [DATA_W-1:0] req_wdata,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [DATA_W-1:0]      rsp_rdata,
   output logic                   rsp_access_error,
   output logic [IRQ_W-1:0]       rsp_soft_irq,
   output logic [IRQ_W-1:0]       rsp_timer_irq
);

   // Replace one 32-bit half of a 64-bit value
   function automatic logic [TIME_W-1:0] put_half(input logic [TIME_W-1:0] v,
                                                  input logic hi,
                                                  input logic [DATA_W-1:0] w);
      logic [TIME_W-1:0] r;
      r = v;
      if (hi) begin
         r[TIME_W-1:DATA_W] = w;
      end else begin
         r[DATA_W-1:0] = w;
      end
      return r;
   endfunction

   // Request register
   logic              s1_valid_ff, s1_valid_in;
   logic [1:0]        s1_cmd_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [DATA_W-1:0] s1_wdata_ff;

   // State
   logic [TIME_W-1:0] time_ff, time_in;
   logic [TIME_W-1:0] cmp_ff [HARTS];
   logic [TIME_W-1:0] cmp_in [HARTS];
   logic [HARTS-1:0]  soft_ff, soft_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rdata_ff, rdata_in;
   logic              err_ff, err_in;
   logic [IRQ_W-1:0]  sirq_ff, sirq_in;
   logic [IRQ_W-1:0]  tirq_ff, tirq_in;

   logic    req_xfer;
   logic    out_free;
   logic    s1_go;
   logic    is_wr;
   logic    is_rd;
   logic    is_tick;
   cmd_type op;
   dec_type dec;

   // Handshake
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_go       = s1_valid_ff && out_free;
   assign req_stall   = s1_valid_ff && !out_free;
   assign req_xfer    = req_valid && !req_stall;
   assign s1_valid_in = req_xfer || (s1_valid_ff && !s1_go);
   assign rsp_valid_in = s1_go || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_cmd_ff   <= req_cmd;
         s1_addr_ff  <= req_addr;
         s1_wdata_ff <= req_wdata;
      end
   end

   // Decode of the held request
   clint_dec u_dec (
      .cmd  (s1_cmd_ff),
      .addr (s1_addr_ff),
      .dec  (dec)
   );

   assign op      = cmd_type'(s1_cmd_ff);
   assign is_wr   = (op == CMD_WRITE) && !dec.err;
   assign is_rd   = (op == CMD_READ) && !dec.err;
   assign is_tick = (op == CMD_TICK);

   // Next state
   always_comb begin
      time_in = time_ff;
      if (is_tick) begin
         time_in = time_ff + TIME_W'(1);
      end else if (is_wr && dec.time_hit) begin
         time_in = put_half(time_ff, dec.hi, s1_wdata_ff);
      end
      for (int h = 0; h < HARTS; h++) begin
         cmp_in[h]  = cmp_ff[h];
         soft_in[h] = soft_ff[h];
         if (is_wr && dec.cmp_hit && (dec.hart == HART_W'(h))) begin
            cmp_in[h] = put_half(cmp_ff[h], dec.hi, s1_wdata_ff);
         end
         if (is_wr && dec.msip_hit && (dec.hart == HART_W'(h))) begin
            soft_in[h] = s1_wdata_ff[0];
         end
      end
   end

   // Read data
   always_comb begin
      rdata_in = '0;
      if (is_rd) begin
         priority if (dec.msip_hit) begin
            rdata_in = {{(DATA_W-1){1'b0}}, soft_ff[dec.hart]};
         end else if (dec.cmp_hit) begin
            rdata_in = dec.hi ? cmp_ff[dec.hart][TIME_W-1:DATA_W]
                              : cmp_ff[dec.hart][DATA_W-1:0];
         end else if (dec.time_hit) begin
            rdata_in = dec.hi ? time_ff[TIME_W-1:DATA_W] : time_ff[DATA_W-1:0];
         end
      end
   end

   assign err_in = dec.err;

   // Interrupt lines after the update; lines beyond the hart count are tied low
   for (genvar g = 0; g < IRQ_W; g++) begin : g_irq
      if (g < HARTS) begin : g_hart
         assign sirq_in[g] = soft_in[g];
         assign tirq_in[g] = (time_in >= cmp_in[g]);
      end else begin : g_none
         assign sirq_in[g] = 1'b0;
         assign tirq_in[g] = 1'b0;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
         soft_ff <= '0;
         for (int h = 0; h < HARTS; h++) begin
            cmp_ff[h] <= '1;
         end
      end else if (s1_go) begin
         time_ff <= time_in;
         soft_ff <= soft_in;
         for (int h = 0; h < HARTS; h++) begin
            cmp_ff[h] <= cmp_in[h];
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rdata_ff <= rdata_in;
         err_ff   <= err_in;
         sirq_ff  <= sirq_in;
         tirq_ff  <= tirq_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rdata        = rdata_ff;
   assign rsp_access_error = err_ff;
   assign rsp_soft_irq     = sirq_ff;
   assign rsp_timer_irq    = tirq_ff;

endmodule

`default_nettype wire

// File: rtl/clint_dec.sv
// Address decoder of the core-local interruptor: region, hart, word half and error.
`default_nettype none

module clint_dec
   import clint_pkg::*;
(
   input  wire logic [1:0]        cmd,
   input  wire logic [ADDR_W-1:0] addr,
   output dec_type                dec
);

   logic    aligned;
   logic    is_access;
   logic    msip_rng;
   logic    cmp_rng;
   logic    time_rng;
   cmd_type op;

   assign op        = cmd_type'(cmd);
   assign aligned   = (addr[1:0] == 2'b00);
   assign is_access = (op == CMD_READ) || (op == CMD_WRITE);

   // Region checks
   assign msip_rng = (addr >= MSIP_BASE) && (addr < MSIP_END);
   assign cmp_rng  = (addr >= CMP_BASE) && (addr < CMP_END);
   assign time_rng = (addr[ADDR_W-1:3] == TIME_BASE[ADDR_W-1:3]);

   always_comb begin
      dec          = '0;
      dec.msip_hit = aligned && msip_rng;
      dec.cmp_hit  = aligned && cmp_rng;
      dec.time_hit = aligned && time_rng;
      dec.hi       = addr[2];
      // msip words are 4 bytes apart, compare words 8 bytes apart
      if (cmp_rng) begin
         dec.hart = addr[HART_W+2:3];
      end else begin
         dec.hart = addr[HART_W+1:2];
      end
      dec.err = is_access && !(dec.msip_hit || dec.cmp_hit || dec.time_hit);
   end

endmodule

`default_nettype wire

// File: rtl/clint_chk.sv
// Port-level checker of the core-local interruptor and its bind to the top level.
`default_nettype none

module clint_chk
   import clint_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [DATA_W-1:0] rsp_rdata,
   input wire logic              rsp_access_error,
   input wire logic [IRQ_W-1:0]  rsp_soft_irq,
   input wire logic [IRQ_W-1:0]  rsp_timer_irq
);

   // No result is left over from before reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rdata)
         && $stable(rsp_access_error) && $stable(rsp_soft_irq) && $stable(rsp_timer_irq))
      else $error("stalled result changed");

   // A failed access returns no data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_access_error |-> rsp_rdata == '0)
      else $error("access error with nonzero read data");

   // A result appearing from empty comes from an earlier request transfer
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching request transfer");

endmodule

bind core_local_timer_interruptor clint_chk u_clint_chk (.*);

`default_nettype wire
